@@ design/mstt_pkg.sv @@
// Shared types, codes and defaults for the multi-slot timer table.
package mstt_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam logic [9:0]  DUE_CAP        = 10'd1000;

  typedef enum logic [1:0] {
    REQ_ARM_ONCE     = 2'd0,
    REQ_ARM_PERIODIC = 2'd1,
    REQ_CANCEL       = 2'd2,
    REQ_TICK         = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_FIRED = 2'd2,
    STAT_NONE  = 2'd3
  } stat_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic arm_step;
    logic cancel;
    logic tick_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_e in_req;
    logic arm_done;
    logic tick_done;
    logic out_free;
  } sts_t;

endpackage

@@ design/mstt_in_if.sv @@
// Request channel interface of the multi-slot timer table.
interface mstt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [31:0] delay_ms;
  logic [7:0]        slot_id;
  logic [31:0]       current_time;

  modport source (output valid, output req_type, output delay_ms, output slot_id,
                  output current_time, input ready);
  modport sink   (input valid, input req_type, input delay_ms, input slot_id,
                  input current_time, output ready);
endinterface

@@ design/mstt_out_if.sv @@
// Result channel interface of the multi-slot timer table.
interface mstt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_index;
  logic [9:0] next_due_in;
  logic       any_active;

  modport source (output valid, output status, output slot_index, output next_due_in,
                  output any_active, input ready);
  modport sink   (input valid, input status, input slot_index, input next_due_in,
                  input any_active, output ready);
endinterface

@@ design/mstt_ctrl.sv @@
// Sequencing state machine of the multi-slot timer table.
module mstt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mstt_pkg::sts_t   sts_i,
  output mstt_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ARM    = 3'd1;
  localparam logic [2:0] S_CANCEL = 3'd2;
  localparam logic [2:0] S_TICK   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (sts_i.in_req)
            mstt_pkg::REQ_ARM_ONCE,
            mstt_pkg::REQ_ARM_PERIODIC: state_d = S_ARM;
            mstt_pkg::REQ_CANCEL:       state_d = S_CANCEL;
            default:                    state_d = S_TICK;
          endcase
        end
      end
      S_ARM: begin
        cmd_o.arm_step = 1'b1;
        if (sts_i.arm_done) state_d = S_EMIT;
      end
      S_CANCEL: begin
        cmd_o.cancel = 1'b1;
        state_d      = S_EMIT;
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.tick_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/mstt_dp.sv @@
// Slot storage, scan datapath and result registers of the multi-slot timer table.
module mstt_dp #(
  parameter int unsigned SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] delay_ms_i,
  input  logic [7:0]         slot_id_i,
  input  logic [31:0]        current_time_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [3:0]         slot_index_o,
  output logic [9:0]         next_due_in_o,
  output logic               any_active_o,
  input  mstt_pkg::cmd_t     cmd_i,
  output mstt_pkg::sts_t     sts_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  // Captured request
  mstt_pkg::req_e     req_q;
  logic signed [31:0] dly_q;
  logic [7:0]         sid_q;
  logic [31:0]        now_q;

  // Slot occupancy and slot memories
  logic [SLOT_COUNT-1:0] used_q;
  logic [63:0]           due_mem [SLOT_COUNT];
  logic [31:0]           per_mem [SLOT_COUNT];
  logic                  rep_mem [SLOT_COUNT];
  logic [63:0]           due_rd_q;
  logic [31:0]           per_rd_q;
  logic                  rep_rd_q;

  // Scan state
  logic [CNT_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             chk_vld_q;
  logic [9:0]       best_q;
  logic             any_q;

  // Result and output registers
  mstt_pkg::stat_e res_status_q;
  logic [3:0]      res_idx_q;
  logic [9:0]      res_due_q;
  logic            res_any_q;
  logic            out_valid_q;
  mstt_pkg::stat_e out_status_q;
  logic [3:0]      out_idx_q;
  logic [9:0]      out_due_q;
  logic            out_any_q;

  logic [IDX_W-1:0] rd_addr;
  logic             rd_at_end;
  logic             arm_done;
  logic             arm_wr;
  logic [63:0]      diff;
  logic             expired;
  logic             chk_used;
  logic             hit;
  logic             scan_done;
  logic             fire_wr;
  logic             fire_free;
  logic [63:0]      arm_due;
  logic [63:0]      fire_due;
  logic             sid_ok;
  logic             periodic;
  logic             due_we;
  logic [IDX_W-1:0] wr_addr;
  logic [63:0]      wr_due;
  logic             out_free;

  assign rd_addr   = rd_idx_q[IDX_W-1:0];
  assign rd_at_end = (rd_idx_q == CNT_W'(SLOT_COUNT));
  assign arm_done  = rd_at_end || !used_q[rd_addr];
  assign arm_wr    = cmd_i.arm_step && !rd_at_end && !used_q[rd_addr];

  assign diff      = due_rd_q - {32'd0, now_q};
  assign expired   = (diff == 64'd0) || diff[63];
  assign chk_used  = chk_vld_q && used_q[chk_idx_q];
  assign hit       = chk_used && expired;
  assign scan_done = rd_at_end && !chk_vld_q;
  assign fire_wr   = cmd_i.tick_step && hit && rep_rd_q;
  assign fire_free = cmd_i.tick_step && hit && !rep_rd_q;

  assign arm_due   = {32'd0, now_q} + {{32{dly_q[31]}}, dly_q};
  assign fire_due  = due_rd_q + {{32{per_rd_q[31]}}, per_rd_q};
  assign sid_ok    = ({1'b0, sid_q} < 9'(SLOT_COUNT));
  assign periodic  = (req_q == mstt_pkg::REQ_ARM_PERIODIC);

  assign due_we    = arm_wr || fire_wr;
  assign wr_addr   = arm_wr ? rd_addr : chk_idx_q;
  assign wr_due    = arm_wr ? arm_due : fire_due;

  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.in_req    = mstt_pkg::req_e'(req_type_i);
  assign sts_o.arm_done  = arm_done;
  assign sts_o.tick_done = hit || scan_done;
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_idx_q;
  assign next_due_in_o = out_due_q;
  assign any_active_o  = out_any_q;

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= mstt_pkg::req_e'(req_type_i);
      dly_q <= delay_ms_i;
      sid_q <= slot_id_i;
      now_q <= current_time_i;
    end
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (due_we) due_mem[wr_addr] <= wr_due;
    if (arm_wr) begin
      per_mem[wr_addr] <= periodic ? dly_q : 32'd0;
      rep_mem[wr_addr] <= periodic;
    end
    due_rd_q <= due_mem[rd_addr];
    per_rd_q <= per_mem[rd_addr];
    rep_rd_q <= rep_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (arm_wr) used_q[rd_addr] <= 1'b1;
      if (cmd_i.cancel && sid_ok) used_q[sid_q[IDX_W-1:0]] <= 1'b0;
      if (fire_free) used_q[chk_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      best_q    <= mstt_pkg::DUE_CAP;
      any_q     <= 1'b0;
    end else if (cmd_i.load) begin
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      best_q    <= mstt_pkg::DUE_CAP;
      any_q     <= 1'b0;
    end else if (cmd_i.arm_step) begin
      if (!arm_done) rd_idx_q <= rd_idx_q + CNT_W'(1);
    end else if (cmd_i.tick_step && !hit && !scan_done) begin
      // advance the read address and check the slot read last cycle
      if (!rd_at_end) rd_idx_q <= rd_idx_q + CNT_W'(1);
      chk_vld_q <= !rd_at_end;
      chk_idx_q <= rd_addr;
      if (chk_used) begin
        any_q <= 1'b1;
        if (diff < {54'd0, best_q}) best_q <= diff[9:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arm_step && arm_done) begin
      res_status_q <= rd_at_end ? mstt_pkg::STAT_FULL : mstt_pkg::STAT_DONE;
      res_idx_q    <= rd_at_end ? 4'd0 : 4'(rd_addr);
      res_due_q    <= 10'd0;
      res_any_q    <= 1'b0;
    end else if (cmd_i.cancel) begin
      res_status_q <= mstt_pkg::STAT_DONE;
      res_idx_q    <= 4'd0;
      res_due_q    <= 10'd0;
      res_any_q    <= 1'b0;
    end else if (cmd_i.tick_step && hit) begin
      res_status_q <= mstt_pkg::STAT_FIRED;
      res_idx_q    <= 4'(chk_idx_q);
      res_due_q    <= 10'd0;
      res_any_q    <= 1'b1;
    end else if (cmd_i.tick_step && scan_done) begin
      res_status_q <= mstt_pkg::STAT_NONE;
      res_idx_q    <= 4'd0;
      res_due_q    <= best_q;
      res_any_q    <= any_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_due_q    <= res_due_q;
      out_any_q    <= res_any_q;
    end
  end

endmodule

@@ design/multi_slot_timer_table.sv @@
// Cancel clears the named slot flag if the slot number is in range; arm checks one slot flag per
// cycle for the lowest free slot; tick scans the slots through the single read port of the slot
// memory (one slot per cycle, read data registered). One request beat is in flight at a time;
// the next request beat is taken once the result sits in the output register, even if it is not yet taken.
// Reset: slot occupancy flags clear at once, no clearing pass; due time, period and
// repeat memories are left as they are and their contents are only used for occupied slots.
module multi_slot_timer_table #(
  parameter int unsigned SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mstt_in_if.sink    in_i,
  mstt_out_if.source out_o
);

  // Command and status bundles between the sequencer and the datapath
  mstt_pkg::cmd_t cmd;
  mstt_pkg::sts_t sts;

  // Sequencer: decode the request beat, then run the cancel, step the arm search or the tick scan,
  // and hold the finished result until the output register is free
  mstt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: slot flags, slot memories, expiry compare, nearest-expiry minimum,
  // periodic advance and the result/output registers
  mstt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (in_i.req_type),
    .delay_ms_i     (in_i.delay_ms),
    .slot_id_i      (in_i.slot_id),
    .current_time_i (in_i.current_time),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .slot_index_o   (out_o.slot_index),
    .next_due_in_o  (out_o.next_due_in),
    .any_active_o   (out_o.any_active),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ design/mstt_checker.sv @@
// Port-level assertions for the multi-slot timer table, bound to the top level.
module mstt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_status_i,
  input logic [3:0] out_slot_index_i,
  input logic [9:0] out_next_due_in_i,
  input logic       out_any_active_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_slot_index_i) && $stable(out_next_due_in_i)
      && $stable(out_any_active_i))
    else $error("result beat changed while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == mstt_pkg::STAT_FULL) |->
      (out_slot_index_i == 4'd0) && (out_next_due_in_i == 10'd0) && !out_any_active_i)
    else $error("table full result carries data");

  a_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == mstt_pkg::STAT_FIRED) |->
      out_any_active_i && (out_next_due_in_i == 10'd0))
    else $error("fired result inconsistent");

  a_none_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == mstt_pkg::STAT_NONE) |->
      (out_slot_index_i == 4'd0) && (out_next_due_in_i <= mstt_pkg::DUE_CAP))
    else $error("idle tick result out of range");

endmodule

bind multi_slot_timer_table mstt_checker u_mstt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_slot_index_i  (out_o.slot_index),
  .out_next_due_in_i (out_o.next_due_in),
  .out_any_active_i  (out_o.any_active)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the multi-slot timer table: directed and random requests.
module tb_top;

  localparam int unsigned SLOTS      = mstt_pkg::SLOT_COUNT_DEF;
  // Longest legal stretch without any beat: the long receiver hold plus one scan.
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned WDOG_LIMIT = 2500;
  // Worst-case tick scan plus some margin for the final drain.
  localparam int unsigned DRAIN_WAIT = SLOTS + 12;

  // One expected result beat.
  typedef struct packed {
    mstt_pkg::stat_e status;
    logic [3:0]      slot_index;
    logic [9:0]      next_due_in;
    logic            any_active;
  } timer_rsp_t;

  logic clk_i;
  logic rst_ni;

  mstt_in_if  req_if ();
  mstt_out_if rsp_if ();

  multi_slot_timer_table #(
    .SLOT_COUNT (SLOTS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Shadow copy of the slot table, advanced at each accepted request beat.
  logic        slot_busy   [SLOTS];
  logic [63:0] slot_due    [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic        slot_repeat [SLOTS];

  timer_rsp_t  timer_rsp_q [$];
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;

  // Knobs set by the stimulus; the rx and long-hold knobs also steer the receiver process.
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          long_hold_req;
  logic [31:0] wall_ms;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the result of one request and advance the shadow table.
  function automatic timer_rsp_t predict_timer_rsp(input mstt_pkg::req_e kind,
                                                   input logic signed [31:0] dly,
                                                   input logic [7:0] sid,
                                                   input logic [31:0] now);
    timer_rsp_t  rsp;
    logic [63:0] now64;
    logic [63:0] dly64;
    logic [63:0] diff;
    logic [63:0] best;
    logic        done;
    logic        any;
    int          i;
    rsp   = '{status: mstt_pkg::STAT_DONE, slot_index: 4'd0, next_due_in: 10'd0,
              any_active: 1'b0};
    now64 = {32'd0, now};
    dly64 = {{32{dly[31]}}, dly};
    done  = 1'b0;
    any   = 1'b0;
    best  = 64'(mstt_pkg::DUE_CAP);
    case (kind)
      mstt_pkg::REQ_ARM_ONCE, mstt_pkg::REQ_ARM_PERIODIC: begin
        // Take the lowest free slot, or report a full table.
        for (i = 0; i < SLOTS; i++) begin
          if (!done && !slot_busy[i]) begin
            done           = 1'b1;
            slot_busy[i]   = 1'b1;
            slot_due[i]    = now64 + dly64;
            slot_repeat[i] = (kind == mstt_pkg::REQ_ARM_PERIODIC);
            slot_period[i] = (kind == mstt_pkg::REQ_ARM_PERIODIC) ? dly : 32'd0;
            rsp.slot_index = 4'(i);
          end
        end
        if (!done) rsp.status = mstt_pkg::STAT_FULL;
      end
      mstt_pkg::REQ_CANCEL: begin
        // Drop out-of-range slot numbers silently.
        if (sid < SLOTS) slot_busy[sid] = 1'b0;
      end
      default: begin
        // Scan upward; the first expired slot fires and ends the scan.
        for (i = 0; i < SLOTS; i++) begin
          if (!done && slot_busy[i]) begin
            any  = 1'b1;
            diff = slot_due[i] - now64;
            if (diff == 64'd0 || diff[63]) begin
              done = 1'b1;
              if (slot_repeat[i]) begin
                slot_due[i] = slot_due[i] + {{32{slot_period[i][31]}}, slot_period[i]};
              end else begin
                slot_busy[i] = 1'b0;
              end
              rsp.status     = mstt_pkg::STAT_FIRED;
              rsp.slot_index = 4'(i);
              rsp.any_active = 1'b1;
            end else if (diff < best) begin
              best = diff;
            end
          end
        end
        if (!done) begin
          rsp.status      = mstt_pkg::STAT_NONE;
          rsp.next_due_in = best[9:0];
          rsp.any_active  = any;
        end
      end
    endcase
    return rsp;
  endfunction

  // After an optional random idle gap, offer one request beat, hold it until taken, then record its expected result.
  task automatic send_req(input mstt_pkg::req_e kind, input logic signed [31:0] dly,
                          input logic [7:0] sid, input logic [31:0] now);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.delay_ms     <= dly;
    req_if.slot_id      <= sid;
    req_if.current_time <= now;
    do @(posedge clk_i); while (!req_if.ready);
    timer_rsp_q.push_back(predict_timer_rsp(kind, dly, sid, now));
  endtask

  // Mostly a steadily advancing clock with small delays; some noise on every field.
  task automatic send_random_item();
    int unsigned        pick;
    mstt_pkg::req_e     kind;
    logic signed [31:0] dly;
    logic [7:0]         sid;
    logic [31:0]        now;
    pick = $urandom_range(0, 99);
    if (pick < 25)      kind = mstt_pkg::REQ_ARM_ONCE;
    else if (pick < 43) kind = mstt_pkg::REQ_ARM_PERIODIC;
    else if (pick < 55) kind = mstt_pkg::REQ_CANCEL;
    else                kind = mstt_pkg::REQ_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 65)      dly = $urandom_range(1, 400);
    else if (pick < 75) dly = 32'd0 - $urandom_range(0, 50);
    else if (pick < 87) dly = $urandom_range(900, 1600);
    else                dly = $urandom;
    if ($urandom_range(0, 9) < 7) sid = 8'($urandom_range(0, SLOTS - 1));
    else                          sid = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      now = $urandom;
    end else begin
      wall_ms = wall_ms + $urandom_range(0, 40);
      now     = wall_ms;
    end
    send_req(kind, dly, sid, now);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Empty table, a zero delay, a periodic slot across the 32-bit wrap, cancels in
  // and out of range, and a negative delay.
  task automatic test_basic_requests();
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_ARM_ONCE, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_ARM_PERIODIC, 32'sd3, 8'd0, 32'hFFFF_FFFF);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'hFFFF_FFFF);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd2);
    send_req(mstt_pkg::REQ_CANCEL, 32'sd0, 8'hFF, 32'd0);
    send_req(mstt_pkg::REQ_CANCEL, 32'sd0, 8'(SLOTS), 32'd0);
    send_req(mstt_pkg::REQ_CANCEL, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_CANCEL, 32'sd0, 8'd0, 32'd0);
    send_req(mstt_pkg::REQ_ARM_ONCE, 32'sh8000_0000, 8'd0, 32'd5);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd5);
  endtask

  // Fill every slot with the largest delay, overflow once, then reuse the last slot.
  task automatic test_table_full();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      send_req(mstt_pkg::REQ_ARM_ONCE, 32'sh7FFF_FFFF, 8'd0, 32'd100);
    end
    send_req(mstt_pkg::REQ_ARM_PERIODIC, 32'sd1, 8'd0, 32'd100);
    send_req(mstt_pkg::REQ_CANCEL, 32'sd0, 8'(SLOTS - 1), 32'd0);
    send_req(mstt_pkg::REQ_ARM_PERIODIC, 32'sd1, 8'hAA, 32'd100);
    send_req(mstt_pkg::REQ_TICK, 32'sd0, 8'd0, 32'd101);
  endtask

  task automatic test_random_traffic(input int unsigned n, input bit idle);
    int unsigned k;
    tx_idle_en = idle;
    rx_idle_en = idle;
    for (k = 0; k < n; k++) send_random_item();
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the block fills and stalls its request side.
  task automatic test_result_backpressure(input int unsigned n);
    int unsigned k;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    for (k = 0; k < n; k++) send_random_item();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin
    timer_rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (timer_rsp_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %0d/%0d",
                   $time, rsp_if.status, rsp_if.slot_index);
          mismatch_cnt++;
        end else begin
          exp_rsp = timer_rsp_q.pop_front();
          check_field("status", 32'(exp_rsp.status), 32'(rsp_if.status));
          check_field("slot_index", 32'(exp_rsp.slot_index), 32'(rsp_if.slot_index));
          check_field("next_due_in", 32'(exp_rsp.next_due_in), 32'(rsp_if.next_due_in));
          check_field("any_active", 32'(exp_rsp.any_active), 32'(rsp_if.any_active));
        end
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    long_hold_req = 1'b0;
    wall_ms       = 32'd1000;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= mstt_pkg::REQ_TICK;
    req_if.delay_ms     <= 32'sd0;
    req_if.slot_id      <= 8'd0;
    req_if.current_time <= 32'd0;
    rsp_if.ready        <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_requests();
    test_table_full();
    test_random_traffic(500, 1'b1);
    test_result_backpressure(40);
    test_random_traffic(400, 1'b1);
    // Run the last stretch flat out on both sides.
    test_random_traffic(250, 1'b0);

    req_if.valid <= 1'b0;
    while (timer_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
